// File: hw/rtl/weighted_moving_average_defines.svh
// assertion macros for the weighted moving average block
// users must have clk and arst_n in scope
`ifndef WEIGHTED_MOVING_AVERAGE_DEFINES_SVH
`define WEIGHTED_MOVING_AVERAGE_DEFINES_SVH

// checked only while out of reset
`define WMA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define WMA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/wma_pkg.sv
// shared constants and types for the weighted moving average block
// no dependencies
`default_nettype none

package wma_pkg;

	localparam int MAX_PERIOD = 1024;
	localparam int PRICE_BITS = 32;
	localparam int ADDR_W     = $clog2(MAX_PERIOD);
	localparam int BAR_W      = $clog2(MAX_PERIOD + 1);
	// n(n+1)/2 at the largest period
	localparam int TRI_W      = $clog2(MAX_PERIOD * (MAX_PERIOD + 1) / 2 + 1);
	localparam int WSUM_W     = PRICE_BITS + BAR_W - 1;
	localparam int CWS_W      = PRICE_BITS + TRI_W;
	localparam int MUL_A_W    = TRI_W;
	localparam int MUL_P_W    = MUL_A_W + PRICE_BITS;
	localparam int QUO_W      = PRICE_BITS;
	localparam int DIVR_W     = TRI_W;
	localparam int DVD_W      = CWS_W;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EARLY  = 1'd1;

	localparam logic [CFG_W-1:0] PERIOD_RESET = 11'd14;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/weighted_moving_average.sv
// linear weighted moving average over a price stream
// Usage:
//   input channel (in_valid/in_ready) carries price and new_bar; new_bar
//   commits the current bar and opens a new one, otherwise the price revises
//   the current bar. The very first transaction always opens the first bar.
//   output channel (out_valid/out_ready) gives one average and valid_res per
//   input transaction, in order; average reads zero while valid_res is low.
//   config port: cfg_wr_en writes cfg_wdata to register cfg_addr
//   (period, early_output); period writes are dropped once the stream started.
// Timing: one transaction at a time, in_ready low while it is worked on.
//   Transactions on the first bar skip the divider, and the first commit
//   also runs the window init steps. The 32-step divider by n(n+1)/2
//   dominates; products go through one shared registered multiplier.
// Reset clears all control state and the sums; the price window memory is
//   not cleared, only entries committed since reset are ever read.
// A stalled receiver holds the result in the output register; the block
//   still accepts the next transaction and holds its result until the
//   output register frees up.
`default_nettype none
`include "weighted_moving_average_defines.svh"

module weighted_moving_average (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [wma_pkg::PRICE_BITS-1:0] price,
	input  logic                           new_bar,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [wma_pkg::QUO_W-1:0]      average,
	output logic                           valid_res,
	input  logic                           cfg_wr_en,
	input  logic [wma_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [wma_pkg::CFG_W-1:0]      cfg_wdata
);
	import wma_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_INIT_TRI, S_INIT_WS, S_INIT_CWS, S_INIT_STORE,
		S_CMT_READ, S_CMT_MID, S_CMT_FIN, S_AVG_F, S_AVG_T, S_AVG_ADD,
		S_DIV, S_FINISH
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]      period_q;
	logic                  early_q;
	logic                  started_q;
	logic [PRICE_BITS-1:0] p_q;
	logic                  nb_q;
	logic [PRICE_BITS-1:0] cur_q;
	logic [PRICE_BITS-1:0] first_q;
	logic [WSUM_W-1:0]     ws_q;
	logic [CWS_W-1:0]      cws_q;
	logic [BAR_W-1:0]      bc_q;
	logic [ADDR_W-1:0]     wp_q;
	logic [TRI_W-1:0]      tri_q;
	logic [TRI_W-1:0]      f_q;
	logic [WSUM_W-1:0]     mid_q;
	logic [CWS_W:0]        acc_q;
	logic [QUO_W-1:0]      res_q;
	logic                  out_valid_q;
	logic [QUO_W-1:0]      average_q;
	logic                  valid_res_q;

	logic [PRICE_BITS-1:0] window_mem [MAX_PERIOD];
	logic [PRICE_BITS-1:0] rd_data_q;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  mem_we;

	logic [BAR_W-1:0]      n_eff;
	logic [BAR_W-1:0]      n_m1;
	logic [BAR_W-1:0]      n_p1;
	logic [PRICE_BITS-1:0] oldest;
	logic                  valid_now;

	logic [MUL_A_W-1:0]    mul_a;
	logic [PRICE_BITS-1:0] mul_b;
	logic [MUL_P_W-1:0]    mul_p;

	logic                  div_start;
	logic [DVD_W-1:0]      div_dvd;
	logic [QUO_W-1:0]      div_quo;
	div_status_t           div_st;

	// zero acts as one, anything above the window depth as the depth
	always_comb begin
		if (period_q == '0) n_eff = BAR_W'(1);
		else if (BAR_W'(period_q) > BAR_W'(MAX_PERIOD)) n_eff = BAR_W'(MAX_PERIOD);
		else n_eff = BAR_W'(period_q);
	end

	assign n_m1      = n_eff - 1'b1;
	assign n_p1      = n_eff + 1'b1;
	assign rd_addr   = wp_q - n_eff[ADDR_W-1:0];
	assign oldest    = (bc_q >= n_eff) ? rd_data_q : first_q;
	assign valid_now = (({1'b0, bc_q} + 1'b1) >= {1'b0, n_eff}) || early_q;
	assign mem_we    = state_q == S_CMT_MID;

	always_comb begin
		case (state_q)
			S_INIT_TRI: begin
				mul_a = MUL_A_W'(n_eff);
				mul_b = PRICE_BITS'(n_m1);
			end
			S_INIT_WS: begin
				mul_a = MUL_A_W'(n_eff);
				mul_b = first_q;
			end
			S_INIT_CWS: begin
				mul_a = tri_q;
				mul_b = first_q;
			end
			S_CMT_READ: begin
				mul_a = MUL_A_W'(n_m1);
				mul_b = cur_q;
			end
			S_AVG_F: begin
				mul_a = MUL_A_W'(n_eff);
				mul_b = PRICE_BITS'(n_p1);
			end
			S_AVG_T: begin
				mul_a = MUL_A_W'(n_eff);
				mul_b = cur_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = state_q == S_AVG_ADD;
	assign div_dvd   = DVD_W'(mul_p) + cws_q;

	wma_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	wma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (f_q),
		.quotient (div_quo),
		.status   (div_st)
	);

	// oldest entry is read in the cycle before the commit overwrites the slot
	always_ff @(posedge clk) begin
		if (mem_we) window_mem[wp_q] <= cur_q;
		rd_data_q <= window_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			period_q    <= PERIOD_RESET;
			early_q     <= 1'b0;
			started_q   <= 1'b0;
			p_q         <= '0;
			nb_q        <= 1'b0;
			cur_q       <= '0;
			first_q     <= '0;
			ws_q        <= '0;
			cws_q       <= '0;
			bc_q        <= '0;
			wp_q        <= '0;
			tri_q       <= '0;
			f_q         <= '0;
			mid_q       <= '0;
			acc_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			average_q   <= '0;
			valid_res_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_PERIOD: if (!started_q) period_q <= cfg_wdata;
					REG_EARLY:  early_q <= cfg_wdata[0];
					default: ;
				endcase
			end

			// the finish state reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_FINISH) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						p_q     <= price;
						nb_q    <= new_bar;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!started_q) begin
						started_q <= 1'b1;
						cur_q     <= p_q;
						first_q   <= p_q;
						state_q   <= S_AVG_F;
					end else if (nb_q) begin
						state_q <= (bc_q == '0) ? S_INIT_TRI : S_CMT_READ;
					end else begin
						cur_q <= p_q;
						if (bc_q == '0) first_q <= p_q;
						state_q <= S_AVG_F;
					end
				end
				// first commit: window padded with the first price
				S_INIT_TRI: state_q <= S_INIT_WS;
				S_INIT_WS: begin
					tri_q   <= mul_p[TRI_W:1];
					state_q <= S_INIT_CWS;
				end
				S_INIT_CWS: begin
					ws_q    <= mul_p[WSUM_W-1:0];
					state_q <= S_INIT_STORE;
				end
				S_INIT_STORE: begin
					cws_q   <= mul_p[CWS_W-1:0];
					state_q <= S_CMT_READ;
				end
				S_CMT_READ: state_q <= S_CMT_MID;
				S_CMT_MID: begin
					mid_q <= ws_q - WSUM_W'(oldest);
					acc_q <= {1'b0, cws_q} + (CWS_W + 1)'(mul_p);
					wp_q  <= wp_q + 1'b1;
					if (bc_q != BAR_W'(MAX_PERIOD)) bc_q <= bc_q + 1'b1;
					state_q <= S_CMT_FIN;
				end
				S_CMT_FIN: begin
					cws_q   <= CWS_W'(acc_q - (CWS_W + 1)'(mid_q));
					ws_q    <= mid_q + WSUM_W'(cur_q);
					cur_q   <= p_q;
					state_q <= S_AVG_F;
				end
				S_AVG_F: begin
					if (bc_q == '0) begin
						res_q   <= cur_q;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_AVG_T;
					end
				end
				S_AVG_T: begin
					f_q     <= mul_p[TRI_W:1];
					state_q <= S_AVG_ADD;
				end
				S_AVG_ADD: state_q <= S_DIV;
				S_DIV: begin
					if (div_st.done) begin
						res_q   <= div_quo;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						average_q   <= valid_now ? res_q : '0;
						valid_res_q <= valid_now;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign valid_res = valid_res_q;

	`WMA_ASSERT(a_started_sticky, started_q |=> started_q, "started flag dropped")
	`WMA_ASSERT(a_bar_count_sat, bc_q <= BAR_W'(MAX_PERIOD), "bar count past window depth")
	`WMA_ASSERT(a_masked_zero, out_valid_q && !valid_res_q |-> average_q == '0,
		"masked result not zero")
	`WMA_ASSERT(a_div_running, state_q == S_DIV |-> (div_st.busy || div_st.done),
		"waiting on an idle divider")
	`WMA_ASSERT(a_div_nonzero, div_start |-> f_q != '0, "divider started with zero divisor")
	`WMA_ASSERT_ALWAYS(a_reset_clear, !arst_n |-> !out_valid_q && !started_q,
		"state not cleared in reset")

endmodule

`default_nettype wire

// File: hw/rtl/wma_mul.sv
// registered multiplier shared by every product of the sequencer
// depends on wma_pkg
`default_nettype none

module wma_mul (
	input  logic                        clk,
	input  logic [wma_pkg::MUL_A_W-1:0] a,
	input  logic [wma_pkg::PRICE_BITS-1:0] b,
	output logic [wma_pkg::MUL_P_W-1:0] p
);
	import wma_pkg::*;

	always_ff @(posedge clk) begin
		p <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

`default_nettype wire

// File: hw/rtl/wma_div.sv
// restoring divider, one quotient bit per cycle
// depends on wma_pkg; quotient must fit in QUO_W bits
`default_nettype none

module wma_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wma_pkg::DVD_W-1:0]   dividend,
	input  logic [wma_pkg::DIVR_W-1:0]  divisor,
	output logic [wma_pkg::QUO_W-1:0]   quotient,
	output wma_pkg::div_status_t        status
);
	import wma_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
			end
		end
	end

	// high part of the dividend is below the divisor, so it seeds the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DVD_W-1:QUO_W];
			quo_q <= dividend[QUO_W-1:0];
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = cnt_q != '0;
	assign status.done = done_q;

endmodule

`default_nettype wire
